@@ rtl/nel_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nel_pkg
// Shared types and codes for the nearest entry lookup block.
// ----------------------------------------------------------------------------
package nel_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    typedef struct packed {
        logic [31:0] latency;
        logic [39:0] rate;
        logic [15:0] batch;
        logic [7:0]  backend;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     data;
    } cmd_t;

    typedef struct packed {
        logic [31:0] best_latency;
        logic [7:0]  best_backend;
        logic        found;
        logic        accepted;
    } result_t;

    typedef struct packed {
        logic busy;
        logic empty;
    } back_status_t;

endpackage : nel_pkg
`default_nettype wire

@@ rtl/nel_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nel_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : nel_ram
`default_nettype wire

@@ rtl/nel_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nel_front
// Input side: takes beats, turns them into commands and holds them in a
// two-entry queue until the back end pops them.
// ----------------------------------------------------------------------------
module nel_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   in_action,
    input  wire nel_pkg::entry_t in_data,
    output logic              cmd_valid,
    output nel_pkg::cmd_t     cmd,
    input  wire logic         cmd_pop
);

    nel_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    level_reg, level_next;
    logic          push;
    nel_pkg::cmd_t new_cmd;

    always_comb begin
        new_cmd      = '0;
        new_cmd.data = in_data;
        case (in_action)
            nel_pkg::ACT_CLEAR:  new_cmd.op = nel_pkg::ACT_CLEAR;
            nel_pkg::ACT_APPEND: new_cmd.op = nel_pkg::ACT_APPEND;
            nel_pkg::ACT_QUERY:  new_cmd.op = nel_pkg::ACT_QUERY;
            default:             new_cmd.op = nel_pkg::ACT_NONE;
        endcase
    end

    assign in_ready  = (level_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (level_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        level_next  = level_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule : nel_front
`default_nettype wire

@@ rtl/nel_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nel_back
// Command executor: clears, appends to the entry RAM and scans it for the
// nearest entry, one entry a cycle. Holds the result beat until taken.
// ----------------------------------------------------------------------------
module nel_back #(
    parameter int MAX_ENTRIES = 64,
    localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    input  wire nel_pkg::cmd_t     cmd,
    output logic                   cmd_pop,
    output logic                   ram_wr_en,
    output logic [AddrW-1:0]       ram_wr_addr,
    output nel_pkg::entry_t        ram_wr_data,
    output logic                   ram_rd_en,
    output logic [AddrW-1:0]       ram_rd_addr,
    input  wire nel_pkg::entry_t   ram_rd_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output nel_pkg::result_t       res,
    output nel_pkg::back_status_t  status
);

    localparam int CountW = $clog2(MAX_ENTRIES + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] idx_reg, idx_next;
    logic [15:0]       q_batch_reg, q_batch_next;
    logic [39:0]       q_rate_reg, q_rate_next;
    logic              s1_reg, s2_reg;
    logic [15:0]       d1_reg;
    logic [39:0]       d2_reg;
    logic [31:0]       lat_reg;
    logic [7:0]        be_reg;
    logic              found_reg, found_next;
    logic [15:0]       bd1_reg, bd1_next;
    logic [39:0]       bd2_reg, bd2_next;
    logic [31:0]       blat_reg, blat_next;
    logic [7:0]        bbe_reg, bbe_next;
    logic              res_valid_reg, res_valid_next;
    nel_pkg::result_t  res_reg, res_next;
    logic              slot_free;
    logic              better;
    logic [15:0]       d1_calc;
    logic [39:0]       d2_calc;

    assign slot_free   = !res_valid_reg || res_ready;
    assign cmd_pop     = (state_reg == ST_IDLE) && cmd_valid && slot_free;
    assign ram_wr_addr = count_reg[AddrW-1:0];
    assign ram_wr_data = cmd.data;
    assign ram_rd_addr = idx_reg[AddrW-1:0];
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;
    assign status.busy  = (state_reg == ST_SCAN);
    assign status.empty = (count_reg == '0);

    // absolute differences of the entry read last cycle
    always_comb begin
        d1_calc = (ram_rd_data.batch >= q_batch_reg) ? ram_rd_data.batch - q_batch_reg
                                                     : q_batch_reg - ram_rd_data.batch;
        d2_calc = (ram_rd_data.rate >= q_rate_reg) ? ram_rd_data.rate - q_rate_reg
                                                   : q_rate_reg - ram_rd_data.rate;
    end

    // batch first, then rate, then latency; earlier entry keeps a full tie
    assign better = !found_reg || (d1_reg < bd1_reg) ||
                    ((d1_reg == bd1_reg) && ((d2_reg < bd2_reg) ||
                    ((d2_reg == bd2_reg) && (lat_reg < blat_reg))));

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        q_batch_next   = q_batch_reg;
        q_rate_next    = q_rate_reg;
        found_next     = found_reg;
        bd1_next       = bd1_reg;
        bd2_next       = bd2_reg;
        blat_next      = blat_reg;
        bbe_next       = bbe_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (cmd_pop) begin
                    res_next = '0;
                    case (cmd.op)
                        nel_pkg::ACT_CLEAR: begin
                            count_next        = '0;
                            res_next.accepted = 1'b1;
                            res_valid_next    = 1'b1;
                        end
                        nel_pkg::ACT_APPEND: begin
                            if (count_reg < CountW'(MAX_ENTRIES)) begin
                                ram_wr_en         = 1'b1;
                                count_next        = count_reg + CountW'(1);
                                res_next.accepted = 1'b1;
                            end
                            res_valid_next = 1'b1;
                        end
                        nel_pkg::ACT_QUERY: begin
                            if (count_reg == '0) begin
                                res_valid_next = 1'b1;
                            end else begin
                                state_next   = ST_SCAN;
                                idx_next     = '0;
                                found_next   = 1'b0;
                                q_batch_next = cmd.data.batch;
                                q_rate_next  = cmd.data.rate;
                            end
                        end
                        default: begin
                            res_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (idx_reg != count_reg) begin
                    ram_rd_en = 1'b1;
                    idx_next  = idx_reg + CountW'(1);
                end
                if (s2_reg && better) begin
                    found_next = 1'b1;
                    bd1_next   = d1_reg;
                    bd2_next   = d2_reg;
                    blat_next  = lat_reg;
                    bbe_next   = be_reg;
                end
                if ((idx_reg == count_reg) && !s1_reg && !s2_reg) begin
                    res_next.accepted     = 1'b0;
                    res_next.found        = found_reg;
                    res_next.best_backend = found_reg ? bbe_reg : 8'd0;
                    res_next.best_latency = found_reg ? blat_reg : 32'd0;
                    res_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            s1_reg        <= ram_rd_en;
            s2_reg        <= s1_reg;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_batch_reg <= q_batch_next;
        q_rate_reg  <= q_rate_next;
        d1_reg      <= d1_calc;
        d2_reg      <= d2_calc;
        lat_reg     <= ram_rd_data.latency;
        be_reg      <= ram_rd_data.backend;
        bd1_reg     <= bd1_next;
        bd2_reg     <= bd2_next;
        blat_reg    <= blat_next;
        bbe_reg     <= bbe_next;
        res_reg     <= res_next;
    end

endmodule : nel_back
`default_nettype wire

@@ rtl/nearest_entry_lookup.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_entry_lookup
// Table of operating points with clear, append and nearest-entry query.
// ----------------------------------------------------------------------------
// Every input beat gives exactly one result beat. A two-entry command queue
// sits in front of the executor, so up to two beats are taken while it is
// busy. Clear, append and unused actions answer without a scan. A query on
// a table of n entries walks them through the entry RAM's single read port,
// one entry per cycle; an empty table answers without a scan. The entry RAM
// needs no clearing after reset: only entries below the fill count are ever
// read. Nearness is batch distance first, then rate distance, then lower
// latency, with the earliest entry winning a full tie.
module nearest_entry_lookup #(
    parameter int MAX_ENTRIES = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,  // backend_id, batch_size, rate_value, latency_ns
    input  wire logic [1:0]  s_tuser,  // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // best_backend, best_latency
    output logic [1:0]       m_tuser   // accepted, found
);

    localparam int AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic                  cmd_valid;
    nel_pkg::cmd_t         cmd;
    logic                  cmd_pop;
    logic                  ram_wr_en;
    logic [AddrW-1:0]      ram_wr_addr;
    nel_pkg::entry_t       ram_wr_data;
    logic                  ram_rd_en;
    logic [AddrW-1:0]      ram_rd_addr;
    nel_pkg::entry_t       ram_rd_data;
    nel_pkg::result_t      res;
    nel_pkg::back_status_t bst;

    nel_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_data   (nel_pkg::entry_t'(s_tdata)),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    nel_ram #(
        .WIDTH ($bits(nel_pkg::entry_t)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    nel_back #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res),
        .status      (bst)
    );

    assign m_tdata = {res.best_latency, res.best_backend};
    assign m_tuser = {res.found, res.accepted};

`ifndef SYNTHESIS
    a_flags_exclusive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result beat both accepted and found");

    a_not_found_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata == 40'd0))
        else $error("payload not zero without a winner");

    a_scan_no_result : assert property (@(posedge aclk) disable iff (!aresetn)
        bst.busy |-> !m_tvalid)
        else $error("result beat pending during a scan");

    a_found_non_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> !bst.empty)
        else $error("winner reported from an empty table");
`endif

endmodule : nearest_entry_lookup
`default_nettype wire
